// ===== rtl/core/bad_block_remap_table_core_assert.svh =====
// Assertion macros used by the checker file bbrt_chk.sv.
// Each macro expects clk and rst in scope.
`ifndef BAD_BLOCK_REMAP_TABLE_CORE_ASSERT_SVH
`define BAD_BLOCK_REMAP_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define BBRT_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbrt: assertion failed");

// next-cycle implication
`define BBRT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbrt: assertion failed");

`endif

// ===== rtl/core/bbrt_pkg.sv =====
`default_nettype none
package bbrt_pkg;

  localparam int NUM_BLOCKS    = 4096;
  localparam int SPARE_ENTRIES = 64;

  localparam int BLK_W = 12;
  localparam int CNT_OUT_W = 7;
  localparam int IDX_W = (SPARE_ENTRIES > 1) ? $clog2(SPARE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(SPARE_ENTRIES + 1);

  localparam logic [BLK_W-1:0] LAST_BLK = BLK_W'(NUM_BLOCKS - 1);

  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_MARK  = 1'b1;

  localparam logic STS_OK   = 1'b0;
  localparam logic STS_FULL = 1'b1;

  typedef struct packed {
    logic load;
    logic scan;
    logic clear_wr;
    logic append;
    logic res_hit;
    logic res_pass;
    logic res_full;
    logic load_out;
  } bbrt_cmd_t;

  typedef struct packed {
    logic is_mark;
    logic blk_zero;
    logic tbl_full;
    logic match;
    logic scan_end;
    logic out_free;
  } bbrt_sts_t;

  // spare block of entry idx, modulo 2**BLK_W
  function automatic logic [BLK_W-1:0] spare_of(input logic [IDX_W-1:0] idx);
    spare_of = LAST_BLK - BLK_W'(idx);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bbrt_ram.sv =====
`default_nettype none
module bbrt_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/bbrt_ctrl.sv =====
`default_nettype none
module bbrt_ctrl
  import bbrt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire bbrt_sts_t sts,
  output bbrt_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts.is_mark && sts.blk_zero) begin
          cmd.res_pass = 1'b1;
          state_next   = ST_FINISH;
        end else if (sts.is_mark && sts.tbl_full) begin
          cmd.res_full = 1'b1;
          state_next   = ST_FINISH;
        end else if (sts.match) begin
          if (sts.is_mark) begin
            cmd.clear_wr = 1'b1;
            cmd.scan     = 1'b1;
          end else begin
            cmd.res_hit = 1'b1;
            state_next  = ST_FINISH;
          end
        end else if (sts.scan_end) begin
          if (sts.is_mark) begin
            cmd.append = 1'b1;
          end else begin
            cmd.res_pass = 1'b1;
          end
          state_next = ST_FINISH;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/bbrt_dp.sv =====
`default_nettype none
module bbrt_dp
  import bbrt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire bbrt_cmd_t        cmd,
  output bbrt_sts_t             sts,
  input  wire logic             command,
  input  wire logic [BLK_W-1:0] logical_block,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [BLK_W-1:0]      physical_block,
  output logic                  remapped,
  output logic                  status,
  output logic [CNT_OUT_W-1:0]  entry_count
);

  logic             cmd_r;
  logic [BLK_W-1:0] blk_r;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] scan_idx;
  logic [IDX_W-1:0] cmp_idx;
  logic             rd_pend;
  logic [BLK_W-1:0] rd_data;
  logic [BLK_W-1:0] res_phys;
  logic             res_hit;
  logic             res_full;

  logic             issue;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [BLK_W-1:0] ram_wdata;
  logic [CNT_W+CNT_OUT_W-1:0] count_ext;

  assign issue     = cmd.scan && (scan_idx < count);
  assign ram_we    = cmd.clear_wr || cmd.append;
  assign ram_waddr = cmd.append ? count[IDX_W-1:0] : cmp_idx;
  assign ram_wdata = cmd.append ? blk_r : '0;
  assign count_ext = {{CNT_OUT_W{1'b0}}, count};

  bbrt_ram #(
    .WIDTH (BLK_W),
    .DEPTH (SPARE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (rd_data)
  );

  always_comb begin
    sts          = '0;
    sts.is_mark  = (cmd_r == CMD_MARK);
    sts.blk_zero = (blk_r == '0);
    sts.tbl_full = (count >= CNT_W'(SPARE_ENTRIES));
    sts.match    = rd_pend && (rd_data == blk_r);
    sts.scan_end = !rd_pend && (scan_idx >= count);
    sts.out_free = !out_valid || out_ready;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (cmd.append) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= command;
      blk_r    <= logical_block;
      scan_idx <= '0;
    end else if (issue) begin
      scan_idx <= scan_idx + CNT_W'(1);
    end
    if (issue) begin
      cmp_idx <= scan_idx[IDX_W-1:0];
    end
    if (cmd.res_hit) begin
      res_phys <= spare_of(cmp_idx);
      res_hit  <= 1'b1;
      res_full <= STS_OK;
    end else if (cmd.append) begin
      res_phys <= spare_of(count[IDX_W-1:0]);
      res_hit  <= 1'b1;
      res_full <= STS_OK;
    end else if (cmd.res_pass) begin
      res_phys <= blk_r;
      res_hit  <= 1'b0;
      res_full <= STS_OK;
    end else if (cmd.res_full) begin
      res_phys <= '0;
      res_hit  <= 1'b0;
      res_full <= STS_FULL;
    end
    if (cmd.load_out) begin
      physical_block <= res_phys;
      remapped       <= res_hit;
      status         <= res_full;
      entry_count    <= count_ext[CNT_OUT_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bad_block_remap_table_core.sv =====
// channel | signals                                              | handshake
// --------+------------------------------------------------------+-----------------
// in      | command, logical_block                               | in_valid/in_ready
// out     | physical_block, remapped, status, entry_count        | out_valid/out_ready
//
// One item at a time; the time taken per item grows with used_entries (up to 64),
// set by the one-entry-per-cycle scan over the table RAM's registered read port.
// Query of block zero and mark-bad on a full table skip the scan.
// Reset empties the table (entry count to zero); entries need no clearing.
// A result waiting in the output register does not block accepting the next item.
`default_nettype none
module bad_block_remap_table_core
  import bbrt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             command,
  input  wire logic [BLK_W-1:0] logical_block,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [BLK_W-1:0]      physical_block,
  output logic                  remapped,
  output logic                  status,
  output logic [CNT_OUT_W-1:0]  entry_count
);

  bbrt_cmd_t cmd;
  bbrt_sts_t sts;

  bbrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bbrt_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .command        (command),
    .logical_block  (logical_block),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .physical_block (physical_block),
    .remapped       (remapped),
    .status         (status),
    .entry_count    (entry_count)
  );

endmodule
`default_nettype wire

// ===== rtl/core/bbrt_chk.sv =====
`default_nettype none
`include "bad_block_remap_table_core_assert.svh"
module bbrt_chk
  import bbrt_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 command,
  input wire logic [BLK_W-1:0]     logical_block,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [BLK_W-1:0]     physical_block,
  input wire logic                 remapped,
  input wire logic                 status,
  input wire logic [CNT_OUT_W-1:0] entry_count
);

  logic [CNT_W+CNT_OUT_W-1:0] spare_ext;

  assign spare_ext = {{CNT_OUT_W{1'b0}}, CNT_W'(SPARE_ENTRIES)};

  `BBRT_ASSERT_NOW(a_full_no_remap, out_valid && (status == STS_FULL),
    !remapped && (physical_block == '0))
  `BBRT_ASSERT_NOW(a_full_count, out_valid && (status == STS_FULL),
    entry_count == spare_ext[CNT_OUT_W-1:0])
  `BBRT_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
  `BBRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(physical_block) && $stable(entry_count))
  `BBRT_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
    in_valid && $stable(command) && $stable(logical_block))

endmodule

bind bad_block_remap_table_core bbrt_chk u_bbrt_chk (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .command        (command),
  .logical_block  (logical_block),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .physical_block (physical_block),
  .remapped       (remapped),
  .status         (status),
  .entry_count    (entry_count)
);
`default_nettype wire
